// ----- src/cci_pkg.sv -----
// Shared types, widths, step functions and a saturating clamp for the circle intersection pipeline.
package cci_pkg;

  localparam int CoordW   = 32;
  localparam int RadW     = 31;
  localparam int DeltaW   = 33;
  localparam int SqInW    = 66;
  localparam int SqSteps  = SqInW / 2;
  localparam int RootW    = SqSteps;
  localparam int SqRemW   = RootW + 3;
  localparam int NumW     = 66;
  localparam int DenW     = 34;
  localparam int QuoW     = 34;
  localparam int DvRemW   = DenW + 1;
  localparam int Lanes    = 4;
  localparam int PtW      = 34;
  localparam int SumW     = PtW + 1;
  localparam int InDataW  = 192;
  localparam int OutDataW = 128;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic [RadW-1:0]          r0;
    logic [RadW-1:0]          r1;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic [RootW-1:0]         d;
    logic                     hit;
    logic                     aneg;
    logic [RadW-1:0]          am;
    logic [RadW-1:0]          h;
  } ctx_t;

  typedef struct packed {
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_st_t;

  typedef struct packed {
    logic [DvRemW-1:0] rem;
    logic [QuoW-1:0]   quo;
  } dv_st_t;

  // one digit of a restoring square root
  function automatic sq_st_t sqrt_step(sq_st_t s, logic [1:0] pair);
    logic [SqRemW-1:0] r2;
    logic [SqRemW-1:0] t;
    sq_st_t o;
    r2 = {s.rem[SqRemW-3:0], pair};
    t  = {{(SqRemW-RootW-2){1'b0}}, s.root, 2'b01};
    if (r2 >= t) begin
      o.rem  = r2 - t;
      o.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[RootW-2:0], 1'b0};
    end
    return o;
  endfunction

  // one bit of a restoring division
  function automatic dv_st_t div_step(dv_st_t s, logic nbit, logic [DenW-1:0] den);
    logic [DvRemW-1:0] r2;
    dv_st_t o;
    r2 = {s.rem[DvRemW-2:0], nbit};
    if (r2 >= {1'b0, den}) begin
      o.rem = r2 - {1'b0, den};
      o.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    return o;
  endfunction

  // clamp a signed sum to the 32-bit coordinate range
  function automatic logic [CoordW-1:0] sat32(logic [SumW-1:0] v);
    logic [CoordW-1:0] o;
    if (!v[SumW-1] && (|v[SumW-2:CoordW-1])) begin
      o = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v[SumW-1] && !(&v[SumW-2:CoordW-1])) begin
      o = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      o = v[CoordW-1:0];
    end
    return o;
  endfunction

endpackage

// ----- src/cci_sqrt.sv -----
// Pipelined floor square root, one result digit per stage, context carried alongside.
module cci_sqrt import cci_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             sq_valid,
  input  logic [SqInW-1:0] sq_rad,
  input  ctx_t             sq_ctx,
  output logic             rt_valid,
  output logic [RootW-1:0] rt_root,
  output ctx_t             rt_ctx
);

  logic             v_r   [SqSteps];
  sq_st_t           st_r  [SqSteps];
  logic [SqInW-1:0] rad_r [SqSteps];
  ctx_t             ctx_r [SqSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SqSteps; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= sq_valid;
      for (int k = 1; k < SqSteps; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= sqrt_step('0, sq_rad[SqInW-1:SqInW-2]);
      rad_r[0] <= {sq_rad[SqInW-3:0], 2'b00};
      ctx_r[0] <= sq_ctx;
      for (int k = 1; k < SqSteps; k++) begin
        st_r[k]  <= sqrt_step(st_r[k-1], rad_r[k-1][SqInW-1:SqInW-2]);
        rad_r[k] <= {rad_r[k-1][SqInW-3:0], 2'b00};
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  assign rt_valid = v_r[SqSteps-1];
  assign rt_root  = st_r[SqSteps-1].root;
  assign rt_ctx   = ctx_r[SqSteps-1];

endmodule

// ----- src/cci_div.sv -----
// Pipelined restoring divider, saturating quotient, one bit per stage.
module cci_div import cci_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            dv_valid,
  input  logic [NumW-1:0] dv_num,
  input  logic [DenW-1:0] dv_den,
  input  ctx_t            dv_ctx,
  output logic            qt_valid,
  output logic [QuoW-1:0] qt_quo,
  output ctx_t            qt_ctx
);

  logic            v_r   [QuoW];
  dv_st_t          st_r  [QuoW];
  logic [QuoW-1:0] nb_r  [QuoW];
  logic [DenW-1:0] den_r [QuoW];
  logic            ov_r  [QuoW];
  ctx_t            ctx_r [QuoW];
  dv_st_t          init;

  // the high part already at or above the divisor means the quotient overflows
  always_comb begin
    init.rem = {{(DvRemW-(NumW-QuoW)){1'b0}}, dv_num[NumW-1:QuoW]};
    init.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QuoW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= dv_valid;
      for (int k = 1; k < QuoW; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= div_step(init, dv_num[QuoW-1], dv_den);
      nb_r[0]  <= {dv_num[QuoW-2:0], 1'b0};
      den_r[0] <= dv_den;
      ov_r[0]  <= ({{(DenW-(NumW-QuoW)){1'b0}}, dv_num[NumW-1:QuoW]} >= dv_den);
      ctx_r[0] <= dv_ctx;
      for (int k = 1; k < QuoW; k++) begin
        st_r[k]  <= div_step(st_r[k-1], nb_r[k-1][QuoW-1], den_r[k-1]);
        nb_r[k]  <= {nb_r[k-1][QuoW-2:0], 1'b0};
        den_r[k] <= den_r[k-1];
        ov_r[k]  <= ov_r[k-1];
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  assign qt_valid = v_r[QuoW-1];
  assign qt_quo   = ov_r[QuoW-1] ? '1 : st_r[QuoW-1].quo;
  assign qt_ctx   = ctx_r[QuoW-1];

endmodule

// ----- src/cci_qdiv.sv -----
// Four-lane pipelined divider sharing one divisor, one quotient bit per stage.
module cci_qdiv import cci_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            dv_valid,
  input  logic [NumW-1:0] dv_num [Lanes],
  input  logic [DenW-1:0] dv_den,
  input  ctx_t            dv_ctx,
  output logic            qt_valid,
  output logic [QuoW-1:0] qt_quo [Lanes],
  output ctx_t            qt_ctx
);

  logic            v_r   [QuoW];
  dv_st_t          st_r  [QuoW][Lanes];
  logic [QuoW-1:0] nb_r  [QuoW][Lanes];
  logic [DenW-1:0] den_r [QuoW];
  ctx_t            ctx_r [QuoW];
  dv_st_t          init  [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      init[l].rem = {{(DvRemW-(NumW-QuoW)){1'b0}}, dv_num[l][NumW-1:QuoW]};
      init[l].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QuoW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= dv_valid;
      for (int k = 1; k < QuoW; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= dv_den;
      ctx_r[0] <= dv_ctx;
      for (int l = 0; l < Lanes; l++) begin
        st_r[0][l] <= div_step(init[l], dv_num[l][QuoW-1], dv_den);
        nb_r[0][l] <= {dv_num[l][QuoW-2:0], 1'b0};
      end
      for (int k = 1; k < QuoW; k++) begin
        den_r[k] <= den_r[k-1];
        ctx_r[k] <= ctx_r[k-1];
        for (int l = 0; l < Lanes; l++) begin
          st_r[k][l] <= div_step(st_r[k-1][l], nb_r[k-1][l][QuoW-1], den_r[k-1]);
          nb_r[k][l] <= {nb_r[k-1][l][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  assign qt_valid = v_r[QuoW-1];
  assign qt_ctx   = ctx_r[QuoW-1];
  always_comb begin
    for (int l = 0; l < Lanes; l++) qt_quo[l] = st_r[QuoW-1][l].quo;
  end

endmodule

// ----- src/circle_circle_intersection_top.sv -----
// Circle-circle intersection: top level pipeline and stream ports.
// Most stages are in the two 33-stage square roots and two 34-stage dividers.
// Throughput: one word per cycle; the whole pipeline holds only when its last
// stage is full and the output register is still waiting on out_tready.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
module circle_circle_intersection_top import cci_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // first_center_x[31:0], first_center_y[63:32], first_radius[94:64],
  // second_center_x[126:95], second_center_y[158:127], second_radius[189:159]
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // point_a_x[31:0], point_a_y[63:32], point_b_x[95:64], point_b_y[127:96]
  output logic [OutDataW-1:0] out_tdata,
  // hit[0]
  output logic                out_tuser
);

  logic adv;
  logic out_free;

  // stage A: captured input word
  logic a_v_r;
  logic signed [CoordW-1:0] a_x0_r, a_y0_r, a_x1_r, a_y1_r;
  logic [RadW-1:0] a_r0_r, a_r1_r;

  // stage B: deltas and magnitudes
  logic b_v_r;
  ctx_t b_ctx_r;
  ctx_t b_ctx_nxt;
  logic [DeltaW-1:0] b_adx_r, b_ady_r;
  logic signed [DeltaW-1:0] dx_nxt, dy_nxt;

  // stage C: squares
  logic c_v_r;
  ctx_t c_ctx_r;
  logic [SqInW-1:0] c_sqx_r, c_sqy_r;

  // stage D: squared distance
  logic d_v_r;
  ctx_t d_ctx_r;
  logic [SqInW-1:0] d_rad_r;

  logic s1_v;
  logic [RootW-1:0] s1_root;
  ctx_t s1_ctx;

  // stage E: hit test and squares of radii and distance
  logic e_v_r;
  ctx_t e_ctx_r;
  ctx_t e_ctx_nxt;
  logic [2*RadW-1:0] e_r0sq_r, e_r1sq_r;
  logic [2*CoordW-1:0] e_dsq_r;
  logic [RadW-1:0] rdiff;
  logic [RadW:0] rsum;

  // stage F: r0^2 + d^2
  logic f_v_r;
  ctx_t f_ctx_r;
  logic [2*CoordW:0] f_p_r;
  logic [2*RadW-1:0] f_q_r;

  // stage G: signed numerator of a
  logic g_v_r;
  ctx_t g_ctx_r;
  ctx_t g_ctx_nxt;
  logic [2*CoordW:0] g_nmag_r;
  logic g_aneg;

  logic a1_v;
  logic [QuoW-1:0] a1_quo;
  ctx_t a1_ctx;

  // stages H, I, J: clamp a, square it, radicand of h
  logic h_v_r, i_v_r, j_v_r;
  ctx_t h_ctx_r, i_ctx_r, j_ctx_r;
  ctx_t h_ctx_nxt;
  logic [2*RadW-1:0] i_asq_r, i_r0sq_r, j_rad_r;

  logic s2_v;
  logic [RootW-1:0] s2_root;
  ctx_t s2_ctx;
  ctx_t s2_ctx_h;

  // stage K: the four scaled products
  logic k_v_r;
  ctx_t k_ctx_r;
  logic [NumW-1:0] k_num_r [Lanes];
  logic [2*CoordW-1:0] k_prod [Lanes];
  logic [DeltaW-1:0] k_adx, k_ady;

  logic q_v;
  logic [QuoW-1:0] q_quo [Lanes];
  ctx_t q_ctx;

  // stage L: signed offsets, stage M: saturated points
  logic l_v_r;
  logic l_hit_r;
  logic signed [PtW-1:0] l_px_r, l_py_r, l_ox_r, l_oy_r;
  logic signed [PtW-1:0] tq [Lanes];

  logic m_v_r;
  logic m_hit_r;
  logic [OutDataW-1:0] m_data_r;
  logic [SumW-1:0] sum_ax, sum_ay, sum_bx, sum_by;

  logic out_valid_r;
  logic [OutDataW-1:0] out_tdata_r;
  logic out_tuser_r;

  function automatic logic e_r0_ge_r1(ctx_t c);
    return c.r0 >= c.r1;
  endfunction

  // hold everything only when the last stage has a word the output cannot take
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = !m_v_r || out_free;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0; d_v_r <= 1'b0;
      e_v_r <= 1'b0; f_v_r <= 1'b0; g_v_r <= 1'b0;
      h_v_r <= 1'b0; i_v_r <= 1'b0; j_v_r <= 1'b0;
      k_v_r <= 1'b0; l_v_r <= 1'b0; m_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= s1_v;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= a1_v;
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
      k_v_r <= s2_v;
      l_v_r <= q_v;
      m_v_r <= l_v_r;
    end
  end

  always_comb begin
    dx_nxt = {a_x1_r[CoordW-1], a_x1_r} - {a_x0_r[CoordW-1], a_x0_r};
    dy_nxt = {a_y1_r[CoordW-1], a_y1_r} - {a_y0_r[CoordW-1], a_y0_r};
    b_ctx_nxt    = '0;
    b_ctx_nxt.x0 = a_x0_r;
    b_ctx_nxt.y0 = a_y0_r;
    b_ctx_nxt.r0 = a_r0_r;
    b_ctx_nxt.r1 = a_r1_r;
    b_ctx_nxt.dx = dx_nxt;
    b_ctx_nxt.dy = dy_nxt;
    rdiff  = (e_r0_ge_r1(s1_ctx)) ? s1_ctx.r0 - s1_ctx.r1 : s1_ctx.r1 - s1_ctx.r0;
    rsum   = {1'b0, s1_ctx.r0} + {1'b0, s1_ctx.r1};
    e_ctx_nxt     = s1_ctx;
    e_ctx_nxt.d   = s1_root;
    e_ctx_nxt.hit = (s1_root != '0) && (s1_root >= {2'b00, rdiff})
                    && (s1_root <= {1'b0, rsum});
    g_aneg = {3'b000, f_q_r} > f_p_r;
    g_ctx_nxt      = f_ctx_r;
    g_ctx_nxt.aneg = g_aneg;
    // a never exceeds r0
    h_ctx_nxt    = a1_ctx;
    h_ctx_nxt.am = (a1_quo > {3'b000, a1_ctx.r0}) ? a1_ctx.r0 : a1_quo[RadW-1:0];
    k_adx  = s2_ctx.dx[DeltaW-1] ? -s2_ctx.dx : s2_ctx.dx;
    k_ady  = s2_ctx.dy[DeltaW-1] ? -s2_ctx.dy : s2_ctx.dy;
    k_prod[0] = s2_ctx.am * k_adx;
    k_prod[1] = s2_ctx.am * k_ady;
    k_prod[2] = s2_root[RadW-1:0] * k_ady;
    k_prod[3] = s2_root[RadW-1:0] * k_adx;
    s2_ctx_h   = s2_ctx;
    s2_ctx_h.h = s2_root[RadW-1:0];
    for (int l = 0; l < Lanes; l++) begin
      tq[l] = $signed({2'b00, q_quo[l][CoordW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A: unpack the input word
      a_x0_r <= in_tdata[31:0];
      a_y0_r <= in_tdata[63:32];
      a_r0_r <= in_tdata[94:64];
      a_x1_r <= in_tdata[126:95];
      a_y1_r <= in_tdata[158:127];
      a_r1_r <= in_tdata[189:159];

      // B
      b_ctx_r <= b_ctx_nxt;
      b_adx_r <= dx_nxt[DeltaW-1] ? -dx_nxt : dx_nxt;
      b_ady_r <= dy_nxt[DeltaW-1] ? -dy_nxt : dy_nxt;

      // C
      c_ctx_r <= b_ctx_r;
      c_sqx_r <= b_adx_r * b_adx_r;
      c_sqy_r <= b_ady_r * b_ady_r;

      // D
      d_ctx_r <= c_ctx_r;
      d_rad_r <= c_sqx_r + c_sqy_r;

      // E: distance is in, test for a crossing
      e_ctx_r  <= e_ctx_nxt;
      e_r0sq_r <= s1_ctx.r0 * s1_ctx.r0;
      e_r1sq_r <= s1_ctx.r1 * s1_ctx.r1;
      e_dsq_r  <= s1_root[CoordW-1:0] * s1_root[CoordW-1:0];

      // F
      f_ctx_r <= e_ctx_r;
      f_p_r   <= {3'b000, e_r0sq_r} + {1'b0, e_dsq_r};
      f_q_r   <= e_r1sq_r;

      // G
      g_ctx_r  <= g_ctx_nxt;
      g_nmag_r <= g_aneg ? {3'b000, f_q_r} - f_p_r : f_p_r - {3'b000, f_q_r};

      // H
      h_ctx_r <= h_ctx_nxt;

      // I
      i_ctx_r  <= h_ctx_r;
      i_asq_r  <= h_ctx_r.am * h_ctx_r.am;
      i_r0sq_r <= h_ctx_r.r0 * h_ctx_r.r0;

      // J
      j_ctx_r <= i_ctx_r;
      j_rad_r <= i_r0sq_r - i_asq_r;

      // K: h is in, form a*|dx|, a*|dy|, h*|dy|, h*|dx|
      k_ctx_r    <= s2_ctx_h;
      k_num_r[0] <= {2'b00, k_prod[0]};
      k_num_r[1] <= {2'b00, k_prod[1]};
      k_num_r[2] <= {2'b00, k_prod[2]};
      k_num_r[3] <= {2'b00, k_prod[3]};

      // L: put the signs back and add the first center
      l_hit_r <= q_ctx.hit;
      l_px_r  <= $signed({{2{q_ctx.x0[CoordW-1]}}, q_ctx.x0})
                 + ((q_ctx.aneg != q_ctx.dx[DeltaW-1]) ? -tq[0] : tq[0]);
      l_py_r  <= $signed({{2{q_ctx.y0[CoordW-1]}}, q_ctx.y0})
                 + ((q_ctx.aneg != q_ctx.dy[DeltaW-1]) ? -tq[1] : tq[1]);
      l_ox_r  <= q_ctx.dy[DeltaW-1] ? -tq[2] : tq[2];
      l_oy_r  <= q_ctx.dx[DeltaW-1] ? -tq[3] : tq[3];

      // M: saturate, zero when the circles miss
      m_hit_r  <= l_hit_r;
      m_data_r <= l_hit_r ? {sat32(sum_by), sat32(sum_bx), sat32(sum_ay), sat32(sum_ax)}
                          : '0;
    end
  end

  always_comb begin
    sum_ax = {l_px_r[PtW-1], l_px_r} + {l_ox_r[PtW-1], l_ox_r};
    sum_ay = {l_py_r[PtW-1], l_py_r} - {l_oy_r[PtW-1], l_oy_r};
    sum_bx = {l_px_r[PtW-1], l_px_r} - {l_ox_r[PtW-1], l_ox_r};
    sum_by = {l_py_r[PtW-1], l_py_r} + {l_oy_r[PtW-1], l_oy_r};
  end

  cci_sqrt u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .sq_valid (d_v_r),
    .sq_rad   (d_rad_r),
    .sq_ctx   (d_ctx_r),
    .rt_valid (s1_v),
    .rt_root  (s1_root),
    .rt_ctx   (s1_ctx)
  );

  cci_div u_adiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .dv_valid (g_v_r),
    .dv_num   ({1'b0, g_nmag_r}),
    .dv_den   ({g_ctx_r.d, 1'b0}),
    .dv_ctx   (g_ctx_r),
    .qt_valid (a1_v),
    .qt_quo   (a1_quo),
    .qt_ctx   (a1_ctx)
  );

  cci_sqrt u_hsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .sq_valid (j_v_r),
    .sq_rad   ({{(SqInW-2*RadW){1'b0}}, j_rad_r}),
    .sq_ctx   (j_ctx_r),
    .rt_valid (s2_v),
    .rt_root  (s2_root),
    .rt_ctx   (s2_ctx)
  );

  cci_qdiv u_qdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .dv_valid (k_v_r),
    .dv_num   (k_num_r),
    .dv_den   ({1'b0, k_ctx_r.d}),
    .dv_ctx   (k_ctx_r),
    .qt_valid (q_v),
    .qt_quo   (q_quo),
    .qt_ctx   (q_ctx)
  );

  // output register: load only when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_tdata_r <= m_data_r;
      out_tuser_r <= m_hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- src/cci_checker.sv -----
// Port-level checker for the circle intersection block, bound to the top level.
module cci_checker import cci_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser
);

  // a word shown on the output stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // a miss carries all-zero points
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero points");

  // input is never held while the output register is empty
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind circle_circle_intersection_top cci_checker u_cci_checker (.*);
